// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the tokenizer, stok_checker.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/stok_pkg.sv
// Types, constants and helper functions of the source tokenizer.
// Used by stok_front, stok_queue, stok_back, source_tokenizer and stok_checker.
`timescale 1ns / 1ps

package stok_pkg;

    // Counter widths
    localparam int POSITION_BITS = 16;
    localparam int LINE_BITS     = 16;
    localparam int POS_EXT       = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam int LINE_EXT      = (LINE_BITS > 16) ? LINE_BITS : 16;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Token kinds
    localparam logic [3:0] KIND_EOF     = 4'd0;
    localparam logic [3:0] KIND_ILLEGAL = 4'd1;
    localparam logic [3:0] KIND_IDENT   = 4'd2;
    localparam logic [3:0] KIND_INT     = 4'd3;
    localparam logic [3:0] KIND_ASSIGN  = 4'd4;
    localparam logic [3:0] KIND_SEMI    = 4'd5;
    localparam logic [3:0] KIND_LPAREN  = 4'd6;
    localparam logic [3:0] KIND_RPAREN  = 4'd7;
    localparam logic [3:0] KIND_LBRACE  = 4'd8;
    localparam logic [3:0] KIND_RBRACE  = 4'd9;
    localparam logic [3:0] KIND_PLUS    = 4'd10;
    localparam logic [3:0] KIND_MINUS   = 4'd11;
    localparam logic [3:0] KIND_COMMA   = 4'd12;
    localparam logic [3:0] KIND_LET     = 4'd13;
    localparam logic [3:0] KIND_FN      = 4'd14;
    localparam logic [3:0] KIND_RETURN  = 4'd15;

    // Keyword candidate bits
    localparam logic [2:0] CAND_ALL = 3'b111;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
    } token_t;

    // One queue entry: the tokens caused by a single byte
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } entry_t;

    function automatic logic is_alpha_us(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
    endfunction

    function automatic logic is_decimal_char(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    // Kind of a one-byte punctuation token, KIND_EOF when not punctuation
    function automatic logic [3:0] punct_kind(logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            "=":     k = KIND_ASSIGN;
            ";":     k = KIND_SEMI;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            ",":     k = KIND_COMMA;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] let_char(logic [1:0] i);
        logic [7:0] ch;
        unique case (i)
            2'd0:    ch = "l";
            2'd1:    ch = "e";
            2'd2:    ch = "t";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] fn_char(logic i);
        return i ? 8'("n") : 8'("f");
    endfunction

    function automatic logic [7:0] return_char(logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = "r";
            3'd1:    ch = "e";
            3'd2:    ch = "t";
            3'd3:    ch = "u";
            3'd4:    ch = "r";
            3'd5:    ch = "n";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Drop every keyword that lacks character c at index idx
    function automatic logic [2:0] kw_filter(logic [2:0] cand,
                                             logic [POSITION_BITS-1:0] idx,
                                             logic [7:0] c);
        logic [2:0] keep;
        keep[0] = (idx < POSITION_BITS'(3)) && (let_char(idx[1:0]) == c);
        keep[1] = (idx < POSITION_BITS'(2)) && (fn_char(idx[0]) == c);
        keep[2] = (idx < POSITION_BITS'(6)) && (return_char(idx[2:0]) == c);
        return cand & keep;
    endfunction

    // Clamp a position value to the 16-bit token fields
    function automatic logic [15:0] sat_pos(logic [POSITION_BITS-1:0] v);
        logic [POS_EXT-1:0] x;
        x = POS_EXT'(v);
        if (x > POS_EXT'(16'hFFFF))
            return 16'hFFFF;
        return x[15:0];
    endfunction

    // Clamp a line value to the 16-bit token field
    function automatic logic [15:0] sat_line(logic [LINE_BITS-1:0] v);
        logic [LINE_EXT-1:0] x;
        x = LINE_EXT'(v);
        if (x > LINE_EXT'(16'hFFFF))
            return 16'hFFFF;
        return x[15:0];
    endfunction

endpackage

// File: hw/rtl/stok_front.sv
// Front end of the tokenizer: takes one byte a cycle unless the queue is full, tracks word,
// position and line state, builds the token entry the byte causes. Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    input  logic [7:0]            char_in,
    input  logic                  q_full,
    output logic                  push,
    output stok_pkg::entry_t      push_entry
);

    stok_pkg::scan_mode_t                mode_reg, mode_next;
    logic [stok_pkg::POSITION_BITS-1:0]  start_reg, start_next;
    logic [stok_pkg::POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [stok_pkg::LINE_BITS-1:0]      line_reg, line_next;
    logic [2:0]                          cand_reg, cand_next;

    logic                                accept;
    logic [stok_pkg::POSITION_BITS-1:0]  word_len;
    logic [stok_pkg::POSITION_BITS-1:0]  pos_adv;
    logic [stok_pkg::LINE_BITS-1:0]      line_adv;
    logic [3:0]                          pk;
    logic [3:0]                          word_kind;
    logic                                in_word;
    logic                                word_goes_on;
    logic                                have_word;
    logic                                have_char;
    stok_pkg::token_t                    word_tok;
    stok_pkg::token_t                    char_tok;

    assign accept   = char_valid && !q_full;
    assign word_len = pos_reg - start_reg;
    assign pos_adv  = (pos_reg == {stok_pkg::POSITION_BITS{1'b1}}) ? pos_reg
                                                                   : pos_reg + 1'b1;
    assign line_adv = (line_reg == {stok_pkg::LINE_BITS{1'b1}}) ? line_reg
                                                                : line_reg + 1'b1;
    assign pk       = stok_pkg::punct_kind(char_in);

    // Scan state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stok_pkg::MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= stok_pkg::LINE_BITS'(1);
            cand_reg  <= stok_pkg::CAND_ALL;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            cand_reg  <= cand_next;
        end
    end

    // Word kind at the end of a word: INT for a number, else a keyword check on the identifier
    always_comb
    begin
        word_kind = stok_pkg::KIND_IDENT;
        if (mode_reg == stok_pkg::MODE_NUMBER)
            word_kind = stok_pkg::KIND_INT;
        else if (cand_reg[0] && word_len == stok_pkg::POSITION_BITS'(3))
            word_kind = stok_pkg::KIND_LET;
        else if (cand_reg[1] && word_len == stok_pkg::POSITION_BITS'(2))
            word_kind = stok_pkg::KIND_FN;
        else if (cand_reg[2] && word_len == stok_pkg::POSITION_BITS'(6))
            word_kind = stok_pkg::KIND_RETURN;
    end

    // Next state and the tokens of this byte
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        cand_next  = cand_reg;
        have_char  = 1'b0;

        in_word      = (mode_reg == stok_pkg::MODE_IDENT) ||
                       (mode_reg == stok_pkg::MODE_NUMBER);
        word_goes_on = ((mode_reg == stok_pkg::MODE_IDENT) && stok_pkg::is_alpha_us(char_in)) ||
                       ((mode_reg == stok_pkg::MODE_NUMBER) &&
                        stok_pkg::is_decimal_char(char_in));
        have_word    = in_word && !word_goes_on;

        word_tok.kind   = word_kind;
        word_tok.start  = stok_pkg::sat_pos(start_reg);
        word_tok.length = stok_pkg::sat_pos(word_len);
        word_tok.line   = stok_pkg::sat_line(line_reg);

        char_tok.kind   = stok_pkg::KIND_ILLEGAL;
        char_tok.start  = stok_pkg::sat_pos(pos_reg);
        char_tok.length = 16'd1;
        char_tok.line   = stok_pkg::sat_line(line_reg);

        if (word_goes_on)
        begin
            // Word continues: narrow the keyword set of an identifier and move on
            if (mode_reg == stok_pkg::MODE_IDENT)
                cand_next = stok_pkg::kw_filter(cand_reg, word_len, char_in);
            pos_next = pos_adv;
        end
        else
        begin
            mode_next = stok_pkg::MODE_IDLE;
            if (char_in == 8'h00)
            begin
                // End of input: emit EOF and go back to the reset state
                have_char       = 1'b1;
                char_tok.kind   = stok_pkg::KIND_EOF;
                char_tok.length = 16'd0;
                start_next      = '0;
                pos_next        = '0;
                line_next       = stok_pkg::LINE_BITS'(1);
                cand_next       = stok_pkg::CAND_ALL;
            end
            else if (stok_pkg::is_space(char_in))
            begin
                if (char_in == 8'h0A)
                    line_next = line_adv;
                pos_next = pos_adv;
            end
            else if (pk != stok_pkg::KIND_EOF)
            begin
                have_char     = 1'b1;
                char_tok.kind = pk;
                pos_next      = pos_adv;
            end
            else if (stok_pkg::is_alpha_us(char_in))
            begin
                mode_next  = stok_pkg::MODE_IDENT;
                start_next = pos_reg;
                cand_next  = stok_pkg::kw_filter(stok_pkg::CAND_ALL,
                                                 stok_pkg::POSITION_BITS'(0), char_in);
                pos_next   = pos_adv;
            end
            else if (stok_pkg::is_decimal_char(char_in))
            begin
                mode_next  = stok_pkg::MODE_NUMBER;
                start_next = pos_reg;
                cand_next  = stok_pkg::CAND_ALL;
                pos_next   = pos_adv;
            end
            else
            begin
                have_char = 1'b1;
                pos_next  = pos_adv;
            end
        end

        push            = accept && (have_word || have_char);
        push_entry.two  = have_word && have_char;
        push_entry.tok0 = have_word ? word_tok : char_tok;
        push_entry.tok1 = char_tok;
    end

endmodule

// File: hw/rtl/stok_queue.sv
// Short register queue of token entries between the front and back ends.
// Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stok_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output stok_pkg::entry_t  head
);

    stok_pkg::entry_t                slots_reg [stok_pkg::QUEUE_DEPTH];
    logic [stok_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [stok_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [stok_pkg::QCNT_BITS-1:0]  count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == stok_pkg::QCNT_BITS'(stok_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == stok_pkg::QPTR_BITS'(stok_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == stok_pkg::QPTR_BITS'(stok_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: hw/rtl/stok_back.sv
// Back end of the tokenizer: unpacks queue entries into single tokens and holds them in the
// output register until the consumer takes them. Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  stok_pkg::entry_t  q_head,
    output logic              q_pop,
    input  logic              token_stall,
    output logic              token_valid,
    output stok_pkg::token_t  out_tok,
    output logic              out_last
);

    logic              out_valid_reg, out_valid_next;
    logic              pend_valid_reg, pend_valid_next;
    stok_pkg::token_t  out_tok_reg, out_tok_next;
    logic              out_last_reg, out_last_next;
    stok_pkg::token_t  pend_tok_reg, pend_tok_next;
    logic              load;

    assign load        = !out_valid_reg || !token_stall;
    assign token_valid = out_valid_reg;
    assign out_tok     = out_tok_reg;
    assign out_last    = out_last_reg;

    // Pick the next token: the held second token first, then the queue head
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_tok_next    = out_tok_reg;
        out_last_next   = out_last_reg;
        pend_tok_next   = pend_tok_reg;
        q_pop           = 1'b0;
        if (load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_tok_next    = pend_tok_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                q_pop           = 1'b1;
                out_valid_next  = 1'b1;
                out_tok_next    = q_head.tok0;
                out_last_next   = !q_head.two;
                pend_valid_next = q_head.two;
                pend_tok_next   = q_head.tok1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
        pend_tok_reg <= pend_tok_next;
    end

endmodule

// File: hw/rtl/source_tokenizer.sv
// A byte's tokens pass through the token queue and then the output register to the outputs.
// Throughput: one byte per cycle in while char_stall is low, one token per cycle out while
// token_stall is low; a byte that ends a word and also makes a token of its own gives two tokens.
// The four-entry token queue absorbs these bursts; char_stall rises only when it is full.
// Reset (rst_n low, asynchronous): position 0, line 1, not inside a word, queue and output empty.
`timescale 1ns / 1ps

module source_tokenizer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  logic [7:0]   char_in,
    output logic         token_valid,
    input  logic         token_stall,
    output logic [3:0]   token_kind,
    output logic [15:0]  token_start,
    output logic [15:0]  token_length,
    output logic [15:0]  token_line,
    output logic         last_of_run
);

    logic              push;
    stok_pkg::entry_t  push_entry;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    stok_pkg::entry_t  q_head;
    stok_pkg::token_t  out_tok;

    assign char_stall   = q_full;
    assign token_kind   = out_tok.kind;
    assign token_start  = out_tok.start;
    assign token_length = out_tok.length;
    assign token_line   = out_tok.line;

    // Byte classification and scan state
    stok_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_in    (char_in),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Token entry queue
    stok_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    // Token output stage
    stok_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .token_stall (token_stall),
        .token_valid (token_valid),
        .out_tok     (out_tok),
        .out_last    (last_of_run)
    );

endmodule

// File: hw/rtl/stok_checker.sv
// Port-level checks on the token output of source_tokenizer, attached by bind.
// Depends on stok_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stok_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         token_valid,
    input  logic         token_stall,
    input  logic [3:0]   token_kind,
    input  logic [15:0]  token_length,
    input  logic         last_of_run
);

    logic         held;
    logic         eof_tok;
    logic         word_kind;
    logic         one_byte_tok;
    logic [20:0]  out_bits;

    // Observed token shapes
    assign held         = token_valid && token_stall;
    assign eof_tok      = token_valid && (token_kind == stok_pkg::KIND_EOF);
    assign out_bits     = {token_kind, token_length, last_of_run};
    assign word_kind    = (token_kind == stok_pkg::KIND_IDENT) ||
                          (token_kind == stok_pkg::KIND_INT) ||
                          (token_kind == stok_pkg::KIND_LET) ||
                          (token_kind == stok_pkg::KIND_FN) ||
                          (token_kind == stok_pkg::KIND_RETURN);
    assign one_byte_tok = token_valid &&
                          ((token_kind == stok_pkg::KIND_ILLEGAL) ||
                           (token_kind >= stok_pkg::KIND_ASSIGN &&
                            token_kind <= stok_pkg::KIND_COMMA));

    // A stalled token stays offered with its kind, length and last flag unchanged
    `ASSERT_NEXT(a_out_hold, clk, rst_n, held, token_valid && $stable(out_bits))

    // EOF has no characters and always closes its byte's run
    `ASSERT_IMPLIES(a_eof_shape, clk, rst_n, eof_tok, token_length == 16'd0 && last_of_run)

    // Only a word or number token can be followed by a second one from the same byte
    `ASSERT_IMPLIES(a_first_is_word, clk, rst_n, token_valid && !last_of_run, word_kind)

    // Punctuation and illegal tokens are one byte long
    `ASSERT_IMPLIES(a_single_byte, clk, rst_n, one_byte_tok, token_length == 16'd1)

endmodule

bind source_tokenizer stok_checker u_stok_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_length (token_length),
    .last_of_run  (last_of_run)
);
